// ===== rtl/gsm_fixed_point_alu_defines.svh =====
// Assertion macros shared by the checker of the fixed-point ALU.
`ifndef GSM_FIXED_POINT_ALU_DEFINES_SVH
`define GSM_FIXED_POINT_ALU_DEFINES_SVH
// Checks that an implication holds on every rising clock edge outside reset.
`define GFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks an implication that must hold even while reset is asserted.
`define GFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/gfa_pkg.sv =====
// Package of the fixed-point ALU: commands, widths and the stage payload type.
package gfa_pkg;
  localparam int unsigned NumStages = 16;
  localparam int unsigned DivBits = 15;
  localparam int unsigned DataBytes = 13;

  typedef enum logic [3:0] {
    CmdAdd   = 4'd0,
    CmdSub   = 4'd1,
    CmdMult  = 4'd2,
    CmdMultR = 4'd3,
    CmdAbs   = 4'd4,
    CmdDiv   = 4'd5,
    CmdLMult = 4'd6,
    CmdLAdd  = 4'd7,
    CmdLSub  = 4'd8,
    CmdNorm  = 4'd9
  } cmd_e;

  // Work carried from one cell to the next.
  typedef struct packed {
    logic        valid;
    logic [3:0]  cmd;
    logic [15:0] num;     // division remainder
    logic [15:0] den;
    logic [14:0] quot;
    logic [31:0] res;     // result of every command except divide
    logic        inv;
    logic        skip;    // divide already settled (equal or invalid)
  } stage_t;
endpackage

// ===== rtl/gsm_fixed_point_alu.sv =====
// Pipelined GSM 06.10 fixed-point ALU. One operation is accepted every cycle
// while the output is not stalled: one cell computes all commands but the divide
// quotient into its register, then a chain of 15 divide cells each forms one
// quotient bit, and the output is taken from the last cell.
// The whole chain advances whenever the output register is empty or taken.
module gsm_fixed_point_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // command, short_a, short_b, long_a, long_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result, invalid
);
  import gfa_pkg::*;

  stage_t chain [DivBits+1];
  logic   en;
  stage_t last;
  logic [31:0] res;

  assign en = !chain[DivBits].valid || m_axis_tready;
  assign s_axis_tready = en;

  gfa_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid),
    .command_i(s_axis_tdata[3:0]),
    .short_a_i(s_axis_tdata[19:4]),
    .short_b_i(s_axis_tdata[35:20]),
    .long_a_i(s_axis_tdata[67:36]),
    .long_b_i(s_axis_tdata[99:68]),
    .stage_o(chain[0])
  );

  for (genvar g = 0; g < DivBits; g++) begin : g_div
    gfa_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .stage_i(chain[g]), .stage_o(chain[g+1])
    );
  end

  assign last = chain[DivBits];
  assign res = (last.cmd == CmdDiv) ? (last.inv ? 32'd0 : {17'd0, last.quot}) : last.res;
  assign m_axis_tvalid = last.valid;
  assign m_axis_tdata  = {7'd0, last.inv, res};
endmodule

// ===== rtl/gfa_front.sv =====
// First cell: computes every command but the divide quotient and prepares the divide.
module gfa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [3:0]          command_i,
  input  logic signed [15:0]  short_a_i,
  input  logic signed [15:0]  short_b_i,
  input  logic signed [31:0]  long_a_i,
  input  logic signed [31:0]  long_b_i,
  output gfa_pkg::stage_t     stage_o
);
  import gfa_pkg::*;

  stage_t stage_d, stage_q;
  logic signed [31:0] prod;
  logic signed [32:0] sum16, lsum;
  logic signed [31:0] rnd;
  logic               minmin;
  logic [31:0]        nx;
  logic [4:0]         cnt;
  logic               found;

  always_comb begin
    prod   = short_a_i * short_b_i;
    minmin = (short_a_i == -16'sd32768) && (short_b_i == -16'sd32768);
    rnd    = prod + 32'sd16384;
    sum16  = 33'sd0;
    lsum   = 33'sd0;
    nx     = long_a_i[31] ? ~long_a_i : long_a_i;
    cnt    = 5'd0;
    found  = 1'b0;
    for (int i = 30; i >= 0; i--) begin
      if (!found && nx[i]) begin
        found = 1'b1;
        cnt   = 5'(30 - i);
      end
    end
    if (!found) cnt = 5'd31;
    stage_d       = '0;
    stage_d.valid = valid_i;
    stage_d.cmd   = command_i;
    stage_d.num   = short_a_i;
    stage_d.den   = short_b_i;
    case (command_i)
      CmdAdd, CmdSub: begin
        sum16 = (command_i == CmdAdd) ? 33'(short_a_i) + 33'(short_b_i)
                                      : 33'(short_a_i) - 33'(short_b_i);
        if (sum16 > 33'sd32767) stage_d.res = 32'sd32767;
        else if (sum16 < -33'sd32768) stage_d.res = -32'sd32768;
        else stage_d.res = sum16[31:0];
      end
      CmdMult: stage_d.res = minmin ? 32'sd32767 : 32'(prod >>> 15);
      CmdMultR: stage_d.res = minmin ? 32'sd32767 : 32'(rnd >>> 15);
      CmdAbs: begin
        if (short_a_i == -16'sd32768) stage_d.res = 32'sd32767;
        else if (short_a_i[15]) stage_d.res = -32'(short_a_i);
        else stage_d.res = 32'(short_a_i);
      end
      CmdDiv: begin
        if (short_a_i[15] || short_b_i < short_a_i) begin
          stage_d.inv  = 1'b1;
          stage_d.skip = 1'b1;
        end else if (short_a_i == short_b_i) begin
          stage_d.quot = 15'h7fff;
          stage_d.skip = 1'b1;
        end
      end
      CmdLMult: stage_d.res = minmin ? 32'h7fffffff : {prod[30:0], 1'b0};
      CmdLAdd, CmdLSub: begin
        lsum = (command_i == CmdLAdd) ? 33'(long_a_i) + 33'(long_b_i)
                                      : 33'(long_a_i) - 33'(long_b_i);
        if (lsum[32] != lsum[31]) stage_d.res = lsum[32] ? 32'h80000000 : 32'h7fffffff;
        else stage_d.res = lsum[31:0];
      end
      CmdNorm: begin
        if (long_a_i == 32'sd0 || long_a_i == 32'h80000000 || long_a_i == 32'hc0000000)
          stage_d.res = 32'd0;
        else stage_d.res = 32'(cnt);
      end
      default: stage_d.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

// ===== rtl/gfa_div_cell.sv =====
// Divide cell: one restoring quotient bit, then hands the item on.
module gfa_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  gfa_pkg::stage_t stage_i,
  output gfa_pkg::stage_t stage_o
);
  import gfa_pkg::*;

  stage_t stage_d, stage_q;
  logic [16:0] shifted;
  logic        ge;

  always_comb begin
    stage_d = stage_i;
    shifted = {stage_i.num, 1'b0};
    ge      = shifted >= {1'b0, stage_i.den};
    if (stage_i.cmd == CmdDiv && !stage_i.skip) begin
      stage_d.quot = {stage_i.quot[13:0], ge};
      stage_d.num  = ge ? 16'(shifted - {1'b0, stage_i.den}) : shifted[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

// ===== rtl/gfa_checker.sv =====
// Port checker for the fixed-point ALU, bound to the top level.
`include "gsm_fixed_point_alu_defines.svh"
module gfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `GFA_ASSERT(a_stall_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output changed while stalled")
  `GFA_ASSERT(a_inv_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0), "invalid with nonzero result")
  `GFA_ASSERT(a_ready, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input blocked with free output")
  `GFA_ASSERT_ALWAYS(a_reset, clk_i, !rst_ni |=> !m_axis_tvalid || !rst_ni, "valid after reset")
endmodule

bind gsm_fixed_point_alu gfa_checker u_gfa_checker (.*);

// ===== sim/gsm_fixed_point_alu_tb.sv =====
// Self-checking testbench of the pipelined GSM fixed-point ALU.
module gsm_fixed_point_alu_tb;
  import gfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] sa;
    logic [15:0] sb;
    logic [31:0] la;
    logic [31:0] lb;
  } op_t;

  typedef struct packed {
    logic [31:0] res;
    logic        inv;
  } ans_t;

  localparam int Latency = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  op_t  pending_ops[$];
  ans_t expected_answers[$];
  int   errors = 0;
  int   answers_seen = 0;
  int   idle_mode = 0;   // 0: sender 33/receiver 66, 1: reversed, 2: none
  int   hold_cycles = 0; // long receiver hold-off
  bit   loading_done = 1'b0;
  int   per_cmd[16];

  gsm_fixed_point_alu u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[31:0];
  endfunction

  // Computes the expected result of one ALU operation.
  function automatic ans_t alu_answer(op_t op);
    ans_t   ans;
    longint a, b, la, lb, p, num, den;
    int     q, c;
    logic [31:0] u;
    a = longint'($signed(op.sa));
    b = longint'($signed(op.sb));
    la = longint'($signed(op.la));
    lb = longint'($signed(op.lb));
    p = a * b;
    ans.inv = 1'b0;
    ans.res = '0;
    case (op.cmd)
      CmdAdd: ans.res = sat16(a + b);
      CmdSub: ans.res = sat16(a - b);
      CmdMult: ans.res = (a == -32768 && b == -32768) ? 32'd32767 : 32'(p >>> 15);
      CmdMultR: ans.res = (a == -32768 && b == -32768) ? 32'd32767
                                                       : sat16((p + 16384) >>> 15);
      CmdAbs: ans.res = (a == -32768) ? 32'd32767 : sat16(a < 0 ? -a : a);
      CmdDiv: begin
        if (a < 0 || b < a) begin
          ans.inv = 1'b1;
        end else if (a == b) begin
          ans.res = 32'd32767;
        end else begin
          num = a;
          den = b;
          q = 0;
          for (int k = 0; k < 15; k++) begin
            q = q << 1;
            num = num << 1;
            if (num >= den) begin
              num -= den;
              q += 1;
            end
          end
          ans.res = q;
        end
      end
      CmdLMult: ans.res = sat32(p * 2);
      CmdLAdd: ans.res = sat32(la + lb);
      CmdLSub: ans.res = sat32(la - lb);
      CmdNorm: begin
        u = op.la;
        c = 0;
        if (!(la == 0 || la == -64'sd2147483648 || la == -64'sd1073741824)) begin
          while ((u[30] == u[31]) && c < 31) begin
            u = u << 1;
            c++;
          end
        end
        ans.res = c;
      end
      default: ans.res = '0;
    endcase
    return ans;
  endfunction

  function automatic logic [15:0] edge16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] edge32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'hc000_0000;
      5: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t make_op(logic [3:0] cmd, logic [15:0] sa, logic [15:0] sb,
                                  logic [31:0] la, logic [31:0] lb);
    op_t op;
    op.cmd = cmd;
    op.sa = sa;
    op.sb = sb;
    op.la = la;
    op.lb = lb;
    return op;
  endfunction

  function automatic op_t random_op();
    op_t op;
    op.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
    op.sa = edge16();
    op.sb = edge16();
    op.la = edge32();
    op.lb = edge32();
    // Most divides get valid operands so the quotient chain is exercised.
    if (op.cmd == CmdDiv && $urandom_range(0, 3) != 0) begin
      op.sa = 16'($urandom_range(0, 32767));
      op.sb = 16'($urandom_range(op.sa, 32767));
    end
    return op;
  endfunction

  // Driver: offers the oldest pending item, with random gaps per mode.
  always @(posedge clk_i) begin
    bit offer;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = pending_ops.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 33) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 66);
        if (offer) begin
          op_t op;
          op = pending_ops.pop_front();
          expected_answers.push_back(alu_answer(op));
          per_cmd[op.cmd]++;
          s_axis_tdata <= {4'b0, op.lb, op.la, op.sb, op.sa, op.cmd};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here.
  always @(posedge clk_i) begin
    bit stall;
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        stall = 1'b1;
      end else begin
        stall = (idle_mode == 0 && $urandom_range(0, 99) < 66) ||
                (idle_mode == 1 && $urandom_range(0, 99) < 33);
      end
      m_axis_tready <= !stall;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    ans_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        want = expected_answers.pop_front();
        if (m_axis_tdata[31:0] !== want.res) begin
          errors++;
          $display("%0t: result expected %h actual %h", $time, want.res,
                   m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[32] !== want.inv) begin
          errors++;
          $display("%0t: invalid expected %b actual %b", $time, want.inv,
                   m_axis_tdata[32]);
        end
      end
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed corner cases: saturation, minus one squared, divide rules, norm, an unused code.
    pending_ops.push_back(make_op(CmdAdd, 16'h7fff, 16'h0001, 0, 0));
    pending_ops.push_back(make_op(CmdAdd, 16'h8000, 16'hffff, 0, 0));
    pending_ops.push_back(make_op(CmdSub, 16'h8000, 16'h0001, 0, 0));
    pending_ops.push_back(make_op(CmdSub, 16'h7fff, 16'h8000, 0, 0));
    pending_ops.push_back(make_op(CmdMult, 16'h8000, 16'h8000, 0, 0));
    pending_ops.push_back(make_op(CmdMult, 16'h8000, 16'h7fff, 0, 0));
    pending_ops.push_back(make_op(CmdMultR, 16'h8000, 16'h8000, 0, 0));
    pending_ops.push_back(make_op(CmdMultR, 16'h7fff, 16'h7fff, 0, 0));
    pending_ops.push_back(make_op(CmdAbs, 16'h8000, 0, 0, 0));
    pending_ops.push_back(make_op(CmdAbs, 16'hffff, 0, 0, 0));
    pending_ops.push_back(make_op(CmdDiv, 16'h0000, 16'h0000, 0, 0));
    pending_ops.push_back(make_op(CmdDiv, 16'h1234, 16'h1234, 0, 0));
    pending_ops.push_back(make_op(CmdDiv, 16'hffff, 16'h0005, 0, 0));
    pending_ops.push_back(make_op(CmdDiv, 16'h0005, 16'h0004, 0, 0));
    pending_ops.push_back(make_op(CmdDiv, 16'h0001, 16'h7fff, 0, 0));
    pending_ops.push_back(make_op(CmdLMult, 16'h8000, 16'h8000, 0, 0));
    pending_ops.push_back(make_op(CmdLAdd, 0, 0, 32'h7fff_ffff, 32'h1));
    pending_ops.push_back(make_op(CmdLAdd, 0, 0, 32'h8000_0000, 32'h8000_0000));
    pending_ops.push_back(make_op(CmdLSub, 0, 0, 32'h8000_0000, 32'h1));
    pending_ops.push_back(make_op(CmdNorm, 0, 0, 32'h0, 0));
    pending_ops.push_back(make_op(CmdNorm, 0, 0, 32'h8000_0000, 0));
    pending_ops.push_back(make_op(CmdNorm, 0, 0, 32'hc000_0000, 0));
    pending_ops.push_back(make_op(CmdNorm, 0, 0, 32'hffff_ffff, 0));
    pending_ops.push_back(make_op(CmdNorm, 0, 0, 32'h0000_0001, 0));
    pending_ops.push_back(make_op(4'd15, 16'hffff, 16'hffff, 32'hffff_ffff, 0));
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      idle_mode = phase;
      for (int i = 0; i < 440; i++) pending_ops.push_back(random_op());
      // The long stall lands while items keep arriving, so the pipe fills up.
      if (phase == 2) hold_cycles = 200;
      drain();
    end
    loading_done = 1'b1;
  end

  initial begin
    wait (loading_done);
    while (expected_answers.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    $display("Checked %0d results over %0d command codes, with gaps and stalls on both sides.",
             answers_seen, 16);
    $display("Divide items: %0d, norm items: %0d.", per_cmd[CmdDiv], per_cmd[CmdNorm]);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
